>>> rtl/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg: shared types and constants of the calendar decoder
// Holds the stage payload structs and the calendar tables.
// ---------------------------------------------------------------------------
package scd_pkg;

   localparam logic [11:0] EPOCH_YEAR = 12'd2000;
   localparam logic [2:0]  EPOCH_WDAY = 3'd6;
   localparam logic [8:0]  LEAP_SKIP  = 9'd58;
   localparam int          DAY_W      = 16;   // days since epoch < 49711

   // Day offset past the 2100 skip: days from 2100-03-01 on lose one leap day.
   localparam logic [15:0] D2100  = 16'd36525;   // 2100-01-01 minus 2000-01-01
   localparam logic [15:0] FIX_AT = D2100 + 16'd59;

   // Reciprocals for the constant divides: q = (n * RCP) >> shift.
   localparam logic [31:0] RCP_60   = 32'h8888_8889;   // ceil(2^37 / 60)
   localparam logic [22:0] RCP_45   = 23'd5965233;     // ceil(2^28 / 45)
   localparam logic [16:0] RCP_1461 = 17'd91868;       // ceil(2^27 / 1461)
   localparam logic [17:0] RCP_7    = 18'd149797;      // ceil(2^20 / 7)

   // Stage 1 result: split of the count into time of day and day number.
   typedef struct packed {
      logic [5:0]       sec;
      logic [5:0]       min;
      logic [4:0]       hour;
      logic [DAY_W-1:0] days;
   } tod_type;

   // Stage 2 result: year and day of year.
   typedef struct packed {
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [2:0]  wday;
      logic [11:0] year;
      logic [8:0]  yday;   // already shifted past Feb 29 in common years
   } ydy_type;

   // Final result.
   typedef struct packed {
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [2:0]  wday;
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [11:0] year;
      logic        dst;
   } cal_type;

   // Cumulative days before each month in a leap layout.
   function automatic logic [8:0] month_start(input logic [3:0] m);
      case (m)
         4'd1:    month_start = 9'd0;
         4'd2:    month_start = 9'd31;
         4'd3:    month_start = 9'd60;
         4'd4:    month_start = 9'd91;
         4'd5:    month_start = 9'd121;
         4'd6:    month_start = 9'd152;
         4'd7:    month_start = 9'd182;
         4'd8:    month_start = 9'd213;
         4'd9:    month_start = 9'd244;
         4'd10:   month_start = 9'd274;
         4'd11:   month_start = 9'd305;
         4'd12:   month_start = 9'd335;
         default: month_start = 9'd0;
      endcase
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m);
      case (m)
         4'd2:                    month_len = 5'd29;
         4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
         default:                 month_len = 5'd31;
      endcase
   endfunction

endpackage

>>> rtl/scd_tod.sv
// ---------------------------------------------------------------------------
// scd_tod: time-of-day split
// Two register stages: seconds / minutes, then hours / days.
// ---------------------------------------------------------------------------
module scd_tod (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [31:0]          in_count,
   output logic                 out_valid,
   output scd_pkg::tod_type     out_data
);

   logic        v1_ff;
   logic [5:0]  sec1_ff;
   logic [26:0] mins1_ff;       // count / 60 < 71582789
   logic [63:0] mins_prod;
   logic [63:0] hrs_prod;
   logic [47:0] days_prod;
   logic [5:0]  min_in;
   logic [20:0] hrs_in;         // count / 3600 < 1193047
   logic [scd_pkg::DAY_W-1:0] days_in;
   logic [4:0]  hour_in;
   logic [26:0] mins_in;
   logic [5:0]  sec_in;
   scd_pkg::tod_type data_ff;
   logic        v2_ff;

   // Divide by 60 with a reciprocal multiply; narrow remainder fixes the rest.
   // Days come straight from the minutes as (minutes / 32) / 45.
   always_comb begin
      mins_prod = 64'(in_count) * 64'(scd_pkg::RCP_60);
      mins_in   = mins_prod[63:37];
      sec_in    = in_count[5:0] - 6'({2'b00, mins_in[3:0]} * 6'd60);
      hrs_prod  = 64'(mins1_ff) * 64'(scd_pkg::RCP_60);
      hrs_in    = hrs_prod[57:37];
      min_in    = mins1_ff[5:0] - 6'({2'b00, hrs_in[3:0]} * 6'd60);
      days_prod = 48'(mins1_ff[26:5]) * 48'(scd_pkg::RCP_45);
      days_in   = days_prod[28 +: scd_pkg::DAY_W];
      hour_in   = hrs_in[4:0] - 5'({3'b000, days_in[1:0]} * 5'd24);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         sec1_ff       <= sec_in;
         mins1_ff      <= mins_in;
         data_ff.sec   <= sec1_ff;
         data_ff.min   <= min_in;
         data_ff.hour  <= hour_in;
         data_ff.days  <= days_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/scd_year.sv
// ---------------------------------------------------------------------------
// scd_year: day number to year and day of year
// Two stages: four-year cycle split, then year within the cycle.
// ---------------------------------------------------------------------------
module scd_year (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  scd_pkg::tod_type     in_data,
   output logic                 out_valid,
   output scd_pkg::ydy_type     out_data
);

   logic        v1_ff;
   logic [15:0] adj_in;
   logic [32:0] cyc_prod;
   logic [5:0]  cyc_in;
   logic [10:0] rem_in;
   logic [16:0] wn_in;
   logic [34:0] wq_prod;
   logic [2:0]  wday_in;
   logic [5:0]  cyc_ff;        // four-year cycles
   logic [10:0] rem_ff;        // day within cycle
   logic [2:0]  wday_ff;
   logic [5:0]  sec_ff;
   logic [5:0]  min_ff;
   logic [4:0]  hour_ff;
   logic [1:0]  yq;
   logic [8:0]  yd;
   logic        leap;
   logic        v2_ff;
   scd_pkg::ydy_type data_ff;

   // Count as if 2100 were a leap year by inserting Feb 29 2100.
   // Split by 1461 and by 7 with reciprocal multiplies.
   always_comb begin
      adj_in   = (in_data.days >= scd_pkg::FIX_AT) ? in_data.days + 16'd1 : in_data.days;
      cyc_prod = 33'(adj_in) * 33'(scd_pkg::RCP_1461);
      cyc_in   = cyc_prod[32:27];
      rem_in   = adj_in[10:0] - 11'({5'd0, cyc_in} * 11'd1461);
      wn_in    = 17'(in_data.days) + 17'(scd_pkg::EPOCH_WDAY);
      wq_prod  = 35'(wn_in) * 35'(scd_pkg::RCP_7);
      wday_in  = wn_in[2:0] - 3'(wq_prod[22:20] * 3'd7);
   end

   // The first year of a cycle uses the leap layout as is; 2100 gets its
   // skipped day from the inserted Feb 29 above.
   always_comb begin
      if (rem_ff < 11'd366) begin
         yq = 2'd0; yd = 9'(rem_ff);
      end else if (rem_ff < 11'd731) begin
         yq = 2'd1; yd = 9'(rem_ff - 11'd366);
      end else if (rem_ff < 11'd1096) begin
         yq = 2'd2; yd = 9'(rem_ff - 11'd731);
      end else begin
         yq = 2'd3; yd = 9'(rem_ff - 11'd1096);
      end
      leap = (yq == 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         cyc_ff  <= cyc_in;
         rem_ff  <= rem_in;
         wday_ff <= wday_in;
         sec_ff  <= in_data.sec;
         min_ff  <= in_data.min;
         hour_ff <= in_data.hour;
         data_ff.sec  <= sec_ff;
         data_ff.min  <= min_ff;
         data_ff.hour <= hour_ff;
         data_ff.wday <= wday_ff;
         data_ff.year <= scd_pkg::EPOCH_YEAR + {4'd0, cyc_ff, 2'b00} + 12'(yq);
         data_ff.yday <= (!leap && yd > scd_pkg::LEAP_SKIP) ? yd + 9'd1 : yd;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/scd_month.sv
// ---------------------------------------------------------------------------
// scd_month: day of year to month and day, then summer-time adjust
// Two stages: month search, then the summer-time rule and rollover.
// ---------------------------------------------------------------------------
module scd_month (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  scd_pkg::ydy_type     in_data,
   output logic                 out_valid,
   output scd_pkg::cal_type     out_data
);

   logic       v1_ff;
   logic       v2_ff;
   logic [3:0] mon_in;
   scd_pkg::cal_type mid_ff;
   scd_pkg::cal_type data_ff;
   scd_pkg::cal_type fin;
   logic       past;
   logic       summer;

   always_comb begin
      mon_in = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (in_data.yday >= scd_pkg::month_start(4'(m))) mon_in = 4'(m);
      end
   end

   always_comb begin
      fin  = mid_ff;
      past = ({1'b0, mid_ff.mday} >= 6'd25 + {3'd0, mid_ff.wday})
             && (mid_ff.wday != 3'd0 || mid_ff.hour >= 5'd2);
      if (mid_ff.month < 4'd3 || mid_ff.month > 4'd10) summer = 1'b0;
      else if (mid_ff.month == 4'd3)  summer = past;
      else if (mid_ff.month == 4'd10) summer = !past;
      else summer = 1'b1;
      fin.dst = summer;
      if (summer) begin
         if (mid_ff.hour == 5'd23) begin
            fin.hour = 5'd0;
            fin.wday = (mid_ff.wday == 3'd6) ? 3'd0 : mid_ff.wday + 3'd1;
            if (mid_ff.mday == scd_pkg::month_len(mid_ff.month)) begin
               fin.mday  = 5'd1;
               fin.month = mid_ff.month + 4'd1;
            end else begin
               fin.mday = mid_ff.mday + 5'd1;
            end
         end else begin
            fin.hour = mid_ff.hour + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         mid_ff.sec   <= in_data.sec;
         mid_ff.min   <= in_data.min;
         mid_ff.hour  <= in_data.hour;
         mid_ff.wday  <= in_data.wday;
         mid_ff.year  <= in_data.year;
         mid_ff.month <= mon_in;
         mid_ff.mday  <= 5'(in_data.yday - scd_pkg::month_start(mon_in)) + 5'd1;
         mid_ff.dst   <= 1'b0;
         data_ff      <= fin;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/seconds_to_calendar_dst_unit.sv
// ---------------------------------------------------------------------------
// seconds_to_calendar_dst_unit: seconds count to calendar with summer time
// Six-stage pipeline turning a 32-bit count into date, time and DST flag.
// ---------------------------------------------------------------------------
// Usage:
//   req_ beats carry a 32-bit count of standard-time seconds since
//   2000-01-01 00:00:00. Each yields one rsp_ beat with the calendar
//   fields and the summer-time flag (German rule, last Sunday of March
//   and October at 02:00 standard time).
// Throughput: one beat per cycle while the output is not stalled; the six
//   register stages (two for the time-of-day split, two for the year
//   split, two for month and summer time) all advance together.
// Stall: when rsp_tready is low with a result waiting, the whole pipe
//   holds and req_tready drops; nothing is dropped or repeated.
// Reset: clears all valid bits; no item is in flight afterwards.
// ---------------------------------------------------------------------------
module seconds_to_calendar_dst_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seconds_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // second, minute, hour, weekday,
                                    // day_of_month, month, year, summer_time
);

   logic             adv;
   logic             tod_v;
   logic             ydy_v;
   scd_pkg::tod_type tod_d;
   scd_pkg::ydy_type ydy_d;
   scd_pkg::cal_type cal_d;

   // Advance the whole pipe unless the output holds an untaken beat.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   scd_tod u_tod (
      .clock, .reset, .adv,
      .in_valid (req_tvalid), .in_count (req_tdata),
      .out_valid(tod_v), .out_data(tod_d)
   );

   scd_year u_year (
      .clock, .reset, .adv,
      .in_valid (tod_v), .in_data (tod_d),
      .out_valid(ydy_v), .out_data(ydy_d)
   );

   scd_month u_month (
      .clock, .reset, .adv,
      .in_valid (ydy_v), .in_data (ydy_d),
      .out_valid(rsp_tvalid), .out_data(cal_d)
   );

   // Pack lowest field first, pad to 48 bits.
   assign rsp_tdata = {6'd0, cal_d.dst, cal_d.year, cal_d.month, cal_d.mday,
                       cal_d.wday, cal_d.hour, cal_d.min, cal_d.sec};

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cal_d.hour < 5'd24 && cal_d.mday != 5'd0
                     && cal_d.month != 4'd0 && cal_d.month < 4'd13)
      else $error("calendar field out of range");
`endif

endmodule

>>> dv/seconds_to_calendar_dst_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// seconds_to_calendar_dst_unit_tb: self-checking bench for the calendar decoder
// Drives seconds counts over the request stream, decodes each one in a
// behavioral calendar with the summer-time rule, and compares every response
// beat field by field in order. Both sides idle at random; one long receiver
// hold-off backs the pipe up into the request side.
// ---------------------------------------------------------------------------

typedef struct packed {
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  mday;
   logic [2:0]  wday;
   logic [4:0]  hour;
   logic [5:0]  min;
   logic [5:0]  sec;
   logic        dst;
} cal_fields_type;

function automatic int days_in_year(int y);
   if (y % 4 != 0) return 365;
   if (y % 100 == 0 && y % 400 != 0) return 365;
   return 366;
endfunction

function automatic int days_in_month(int m);
   case (m)
      2:             return 29;
      4, 6, 9, 11:   return 30;
      default:       return 31;
   endcase
endfunction

class calendar_scoreboard;
   cal_fields_type pending[$];
   int             errors;

   function new();
      errors = 0;
   endfunction

   // Decode one count into calendar fields with summer time applied.
   static function cal_fields_type decode_seconds(logic [31:0] count);
      cal_fields_type c;
      longint unsigned s;
      int sec, mn, hr, days, wd, yr, ylen, mo, md;
      bit past, summer;
      s = count;
      sec = int'(s % 60); s = s / 60;
      mn = int'(s % 60); s = s / 60;
      hr = int'(s % 24);
      days = int'(s / 24);
      wd = (days + 6) % 7;
      yr = 2000;
      ylen = days_in_year(yr);
      while (days >= ylen) begin
         days -= ylen;
         yr++;
         ylen = days_in_year(yr);
      end
      // common year: step over the Feb 29 slot of the leap layout
      if (ylen == 365 && days > 58) days++;
      mo = 1;
      while (mo < 12 && days >= days_in_month(mo)) begin
         days -= days_in_month(mo);
         mo++;
      end
      md = days + 1;
      summer = 0;
      if (mo >= 3 && mo <= 10) begin
         past = (md - wd >= 25) && (wd != 0 || hr >= 2);
         summer = past ? (mo != 10) : (mo != 3);
      end
      if (summer) begin
         hr++;
         if (hr == 24) begin
            hr = 0;
            wd = (wd + 1) % 7;
            if (md == days_in_month(mo)) begin
               md = 0;
               mo++;
            end
            md++;
         end
      end
      c.sec = 6'(sec); c.min = 6'(mn); c.hour = 5'(hr); c.wday = 3'(wd);
      c.mday = 5'(md); c.month = 4'(mo); c.year = 12'(yr); c.dst = summer;
      return c;
   endfunction

   function void note_request(logic [31:0] count);
      pending.push_back(decode_seconds(count));
   endfunction

   function void check_response(logic [47:0] data);
      cal_fields_type e;
      if (pending.size() == 0) begin
         $error("response beat with nothing pending: %h", data);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (data[5:0] !== e.sec) begin
         $error("second: expected %0d, got %0d", e.sec, data[5:0]); errors++;
      end
      if (data[11:6] !== e.min) begin
         $error("minute: expected %0d, got %0d", e.min, data[11:6]); errors++;
      end
      if (data[16:12] !== e.hour) begin
         $error("hour: expected %0d, got %0d", e.hour, data[16:12]); errors++;
      end
      if (data[19:17] !== e.wday) begin
         $error("weekday: expected %0d, got %0d", e.wday, data[19:17]); errors++;
      end
      if (data[24:20] !== e.mday) begin
         $error("day_of_month: expected %0d, got %0d", e.mday, data[24:20]);
         errors++;
      end
      if (data[28:25] !== e.month) begin
         $error("month: expected %0d, got %0d", e.month, data[28:25]); errors++;
      end
      if (data[40:29] !== e.year) begin
         $error("year: expected %0d, got %0d", e.year, data[40:29]); errors++;
      end
      if (data[41] !== e.dst) begin
         $error("summer_time: expected %0d, got %0d", e.dst, data[41]); errors++;
      end
      if (data[47:42] !== 6'd0) begin
         $error("pad: expected 0, got %h", data[47:42]); errors++;
      end
   endfunction
endclass

module seconds_to_calendar_dst_unit_tb;

   localparam int RANDOM_ITEMS = 880;
   localparam int STALL_LIMIT  = 5000;   // cycles with no beat at all
   localparam int LONG_HOLD    = 60;     // receiver hold-off, well past pipe depth

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // [5:0] second, [11:6] minute, [16:12] hour,
                             // [19:17] weekday, [24:20] day_of_month,
                             // [28:25] month, [40:29] year, [41] summer_time

   calendar_scoreboard cal_board = new();
   bit   sending_done = 1'b0;
   bit   hold_done    = 1'b0;
   int   idle_cycles  = 0;

   seconds_to_calendar_dst_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Seconds count of day index d (days since epoch) at standard time h:00.
   function automatic logic [31:0] at_day_hour(int d, int h);
      return 32'(d) * 32'd86400 + 32'(h) * 32'd3600;
   endfunction

   // Days since epoch of a given date.
   function automatic int day_number(int y, int m, int d);
      int n;
      n = 0;
      for (int k = 2000; k < y; k++) n += days_in_year(k);
      for (int k = 1; k < m; k++) begin
         n += days_in_month(k);
         if (k == 2 && days_in_year(y) == 365) n--;
      end
      return n + d - 1;
   endfunction

   // Offer one beat after a random gap; hold it until accepted.
   task automatic send_count(logic [31:0] count);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= count;
      do @(posedge clock); while (!req_tready);
      cal_board.note_request(count);
   endtask

   // Random count: switch-over edges, summer month ends, any date or full range.
   function automatic logic [31:0] pick_count();
      int y, m, d;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: begin
            y = $urandom_range(2000, 2135);
            m = ($urandom_range(0, 1) != 0) ? 3 : 10;
            d = $urandom_range(24, 31);
            return at_day_hour(day_number(y, m, d), $urandom_range(0, 3))
                   + $urandom_range(0, 3599);
         end
         2: begin
            // last hours of a month's last day in summer time
            y = $urandom_range(2000, 2135);
            m = $urandom_range(3, 10);
            d = days_in_month(m);
            return at_day_hour(day_number(y, m, d), $urandom_range(21, 23))
                   + $urandom_range(0, 3599);
         end
         default: begin
            y = $urandom_range(2000, 2136);
            m = (y == 2136) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            return at_day_hour(day_number(y, m, $urandom_range(1, 28)),
                               $urandom_range(0, 23)) + $urandom_range(0, 3599);
         end
      endcase
   endfunction

   // Request side: directed edges first, then random counts.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_count(32'd0);
      send_count(32'hFFFF_FFFF);
      send_count(32'h5555_5555);
      send_count(32'hAAAA_AAAA);
      send_count(32'd59);
      send_count(at_day_hour(day_number(2000, 2, 29), 12));   // leap day
      send_count(at_day_hour(day_number(2100, 3, 1), 0));     // 2100 not leap
      send_count(at_day_hour(day_number(2100, 2, 28), 23));
      send_count(at_day_hour(day_number(2000, 3, 26), 1));    // last Sunday, before 2:00
      send_count(at_day_hour(day_number(2000, 3, 26), 2));    // switch to summer
      send_count(at_day_hour(day_number(2000, 10, 29), 1));   // still summer
      send_count(at_day_hour(day_number(2000, 10, 29), 2));   // back to winter
      send_count(at_day_hour(day_number(2000, 3, 31), 23));   // rollover into April
      send_count(at_day_hour(day_number(2000, 6, 30), 23));
      send_count(at_day_hour(day_number(2000, 7, 15), 23));   // hour rollover mid-month
      send_count(at_day_hour(day_number(2000, 12, 31), 23));  // winter, no rollover
      send_count(at_day_hour(day_number(2000, 9, 30), 23));   // into October
      send_count(at_day_hour(day_number(2000, 4, 1), 5));
      for (int i = 0; i < RANDOM_ITEMS; i++) send_count(pick_count());
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // Response side: one long hold-off right after reset, then random ready gaps.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (!hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check every accepted response beat; count silent cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) cal_board.check_response(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Finish once everything has drained, or on a stuck pipe.
   initial begin
      fork
         begin
            while (!(sending_done && cal_board.pending.size() == 0))
               @(posedge clock);
            repeat (20) @(posedge clock);
            if (cal_board.errors == 0 && cal_board.pending.size() == 0)
               $display("** seconds_to_calendar_dst_unit: PASSED **");
            else
               $display("** seconds_to_calendar_dst_unit: FAILED **");
         end
         begin
            wait (idle_cycles >= STALL_LIMIT);
            $error("no beat for %0d cycles", STALL_LIMIT);
            $display("** seconds_to_calendar_dst_unit: FAILED **");
         end
      join_any
      $finish;
   end

endmodule

>>> filelist.f
rtl/scd_pkg.sv
rtl/scd_tod.sv
rtl/scd_year.sv
rtl/scd_month.sv
rtl/seconds_to_calendar_dst_unit.sv
dv/seconds_to_calendar_dst_unit_tb.sv
